>>> hdl/pbp_pkg.sv
// Shared types and constants for the planar byte packer.
// Register map, configuration record, controller states and command/status bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pbp_pkg;

    // Frame geometry defaults
    localparam int ROW_BYTES_DEF = 80;

    // Field widths
    localparam int PIX_W  = 8;
    localparam int COL_W  = 11;
    localparam int ROW_W  = 9;
    localparam int ADDR_W = 16;
    localparam int WID_W  = 10;
    localparam int OFFS_W = 19;
    localparam int DATA_W = 32;
    localparam int PADDR_W = 5;

    // Bit patterns of the byte packing
    localparam logic [7:0] MASK_FULL = 8'hff;
    localparam logic [7:0] BIT_MSB   = 8'h80;
    localparam logic [2:0] BIT_LAST  = 3'd7;
    localparam logic [ROW_W-1:0] ROW_MAX = '1;

    // Foreground bit inside a colour byte
    localparam int FG_BIT = 2;

    // Register indexes (byte address is 4 * index)
    typedef enum logic [2:0] {
        REG_LEFT   = 3'd0,
        REG_TOP    = 3'd1,
        REG_WIDTH  = 3'd2,
        REG_HEIGHT = 3'd3,
        REG_OFFSET = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [WID_W-1:0]  rect_left;
        logic [ROW_W-1:0]  rect_top;
        logic [WID_W-1:0]  rect_width;
        logic [ROW_W-1:0]  rect_height;
        logic [OFFS_W-1:0] start_offset;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic div_start;
        logic load;
        logic step;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } ctrl_stat_t;

endpackage
`default_nettype wire

>>> hdl/pixel_to_planar_byte_packer_core.sv
// Pixel to planar byte packer: top level.
// Uses pbp_pkg, pbp_regs, pbp_div, pbp_dp and pbp_ctrl.
//
// Usage: program the rectangle (left, top, width, height) and the start offset
// over the APB-style port while no transfer is running. Then stream 8-bit
// colour pixels on the s_ channel; bit 2 of each pixel is the foreground bit.
// s_last_pixel marks the final pixel of a transfer. Each m_ request is one
// frame byte write: byte address, bit mask (msb is the leftmost pixel), data
// and a flag that closes the transfer. Pixels on rows below the rectangle
// give no request.
// Timing: the first pixel of a transfer starts a one-bit-per-cycle divide of
// the start offset by the width and is accepted once the result has placed the
// transfer start. Further pixels are accepted one per cycle while the output
// register is free. A write request appears on m_ in the cycle after its pixel.
// Reset: aresetn (synchronous, low) restores register defaults (width 640,
// height 480, others 0) and leaves the block waiting for a new transfer.
// Stall: one output register sits between the channels; while it holds an
// untaken request and m_ready is low, s_ready stays low.
`timescale 1ns / 1ps
`default_nettype none
module pixel_to_planar_byte_packer_core #(
    parameter int ROW_BYTES = pbp_pkg::ROW_BYTES_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [pbp_pkg::PADDR_W-1:0]   paddr,
    input  wire [pbp_pkg::DATA_W-1:0]    pwdata,
    output logic [pbp_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [pbp_pkg::PIX_W-1:0]     s_pixel,
    input  wire                          s_last_pixel,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [pbp_pkg::ADDR_W-1:0]   m_byte_address,
    output logic [7:0]                   m_bit_mask,
    output logic [7:0]                   m_write_data,
    output logic                         m_transfer_end
);
    import pbp_pkg::*;

    cfg_t              cfg;
    logic              cfg_wr;
    ctrl_cmd_t         cmd;
    ctrl_stat_t        stat;
    logic [OFFS_W-1:0] quotient;
    logic [WID_W-1:0]  remainder;
    logic              div_done;
    logic              out_free;
    logic              dropped;

    assign pready        = 1'b1;
    assign stat.div_done = div_done;
    assign stat.out_free = out_free;

    pbp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    pbp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (cfg.start_offset),
        .divisor   (cfg.rect_width),
        .quotient  (quotient),
        .remainder (remainder),
        .done      (div_done)
    );

    pbp_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_last_pixel (s_last_pixel),
        .cfg_wr       (cfg_wr),
        .stat         (stat),
        .cmd          (cmd),
        .s_ready      (s_ready)
    );

    pbp_dp #(
        .ROW_BYTES (ROW_BYTES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .quotient       (quotient),
        .remainder      (remainder),
        .s_pixel        (s_pixel),
        .s_last_pixel   (s_last_pixel),
        .out_free       (out_free),
        .dropped        (dropped),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_byte_address (m_byte_address),
        .m_bit_mask     (m_bit_mask),
        .m_write_data   (m_write_data),
        .m_transfer_end (m_transfer_end)
    );

`ifndef ASSERT_OFF
    // The last pixel closes the transfer: no pixel is taken right after it
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_pixel |=> !s_ready)
        else $error("pixel accepted right after the last pixel");

    // A write always covers at least one pixel
    a_mask_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_bit_mask != 8'h00)
        else $error("write request with empty mask");

    // Data bits never stray outside the mask
    a_data_in_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_write_data & ~m_bit_mask) == 8'h00)
        else $error("write data outside mask");

    // A pixel on a dropped row never produces a write
    a_drop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && dropped && !(m_valid && !m_ready) |=> !m_valid)
        else $error("dropped row produced a write");
`endif

endmodule
`default_nettype wire

>>> hdl/pbp_regs.sv
// Configuration register file behind the APB-style port.
// Depends on pbp_pkg for the register map and the configuration record.
`timescale 1ns / 1ps
`default_nettype none
module pbp_regs (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [pbp_pkg::PADDR_W-1:0]   paddr,
    input  wire [pbp_pkg::DATA_W-1:0]    pwdata,
    output logic [pbp_pkg::DATA_W-1:0]   prdata,
    output pbp_pkg::cfg_t                cfg,
    output logic                         cfg_wr
);
    import pbp_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg_wr = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Decode the write request
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (idx)
                REG_LEFT:   cfg_next.rect_left    = pwdata[WID_W-1:0];
                REG_TOP:    cfg_next.rect_top     = pwdata[ROW_W-1:0];
                REG_WIDTH:  cfg_next.rect_width   = pwdata[WID_W-1:0];
                REG_HEIGHT: cfg_next.rect_height  = pwdata[ROW_W-1:0];
                REG_OFFSET: cfg_next.start_offset = pwdata[OFFS_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rect_left    <= '0;
            cfg_reg.rect_top     <= '0;
            cfg_reg.rect_width   <= WID_W'(640);
            cfg_reg.rect_height  <= ROW_W'(480);
            cfg_reg.start_offset <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb begin
        case (idx)
            REG_LEFT:   prdata = DATA_W'(cfg_reg.rect_left);
            REG_TOP:    prdata = DATA_W'(cfg_reg.rect_top);
            REG_WIDTH:  prdata = DATA_W'(cfg_reg.rect_width);
            REG_HEIGHT: prdata = DATA_W'(cfg_reg.rect_height);
            REG_OFFSET: prdata = DATA_W'(cfg_reg.start_offset);
            default:    prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/pbp_div.sv
// Restoring divider, one quotient bit per cycle: start offset over rectangle width.
// Depends on pbp_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none
module pbp_div (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         start,
    input  wire [pbp_pkg::OFFS_W-1:0]   dividend,
    input  wire [pbp_pkg::WID_W-1:0]    divisor,
    output logic [pbp_pkg::OFFS_W-1:0]  quotient,
    output logic [pbp_pkg::WID_W-1:0]   remainder,
    output logic                        done
);
    import pbp_pkg::*;

    localparam int CNT_W = $clog2(OFFS_W + 1);

    logic [OFFS_W-1:0] quo_reg, quo_next;
    logic [WID_W-1:0]  rem_reg, rem_next;
    logic [WID_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WID_W:0]    trial;
    logic              fits;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, quo_reg[OFFS_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = (divisor == '0) ? WID_W'(1) : divisor;
            cnt_next  = CNT_W'(OFFS_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[OFFS_W-2:0], fits};
            rem_next = fits ? WID_W'(trial - {1'b0, dvs_reg}) : trial[WID_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule
`default_nettype wire

>>> hdl/pbp_dp.sv
// Datapath: row/column tracking, bit gathering and the output register.
// Depends on pbp_pkg; driven by the pbp_ctrl command bundle.
`timescale 1ns / 1ps
`default_nettype none
module pbp_dp #(
    parameter int ROW_BYTES = pbp_pkg::ROW_BYTES_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  pbp_pkg::cfg_t                cfg,
    input  pbp_pkg::ctrl_cmd_t           cmd,
    input  wire [pbp_pkg::OFFS_W-1:0]    quotient,
    input  wire [pbp_pkg::WID_W-1:0]     remainder,
    input  wire [pbp_pkg::PIX_W-1:0]     s_pixel,
    input  wire                          s_last_pixel,
    output logic                         out_free,
    output logic                         dropped,
    input  wire                          m_ready,
    output logic                         m_valid,
    output logic [pbp_pkg::ADDR_W-1:0]   m_byte_address,
    output logic [7:0]                   m_bit_mask,
    output logic [7:0]                   m_write_data,
    output logic                         m_transfer_end
);
    import pbp_pkg::*;

    localparam logic [ADDR_W-1:0] RowStep = ADDR_W'(ROW_BYTES);

    logic [COL_W-1:0]  column_reg, column_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] line_base_reg, line_base_next;
    logic [2:0]        bit_pos_reg, bit_pos_next;
    logic [7:0]        pend_mask_reg, pend_mask_next;
    logic [7:0]        pend_bits_reg, pend_bits_next;
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic [7:0]        m_mask_reg, m_mask_next;
    logic [7:0]        m_data_reg, m_data_next;
    logic              m_end_reg, m_end_next;

    logic [WID_W-1:0]  eff_width;
    logic [COL_W-1:0]  right_col;
    logic [COL_W-1:0]  left_col;
    logic [WID_W:0]    bottom_lim;
    logic [OFFS_W:0]   row_sum;
    logic [ROW_W-1:0]  start_row;
    logic [COL_W-1:0]  start_col;
    logic [7:0]        bits_new;
    logic [7:0]        tail_mask;
    logic              edge_hit;
    logic              row_sat;
    logic [ADDR_W-1:0] cur_addr;

    // Rectangle edges, taken live from the registers
    assign eff_width  = (cfg.rect_width == '0) ? WID_W'(1) : cfg.rect_width;
    assign left_col   = COL_W'(cfg.rect_left);
    assign right_col  = left_col + COL_W'(eff_width) - COL_W'(1);
    assign bottom_lim = (WID_W+1)'(cfg.rect_top) + (WID_W+1)'(cfg.rect_height);
    assign dropped    = (WID_W+1)'(row_reg) >= bottom_lim;

    // Start position from the division result
    assign row_sum   = (OFFS_W+1)'(quotient) + (OFFS_W+1)'(cfg.rect_top);
    assign start_row = (row_sum > (OFFS_W+1)'(ROW_MAX)) ? ROW_MAX : row_sum[ROW_W-1:0];
    assign start_col = COL_W'(remainder) + left_col;

    // Gather the pixel bit and build the partial-byte mask
    assign bits_new  = pend_bits_reg | (s_pixel[FG_BIT] ? (BIT_MSB >> bit_pos_reg) : 8'h00);
    assign tail_mask = MASK_FULL << (BIT_LAST - bit_pos_reg);
    assign edge_hit  = s_last_pixel || (column_reg >= right_col);
    assign row_sat   = (row_reg == ROW_MAX);
    assign cur_addr  = line_base_reg + ADDR_W'(column_reg[COL_W-1:3]);

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        column_next    = column_reg;
        row_next       = row_reg;
        line_base_next = line_base_reg;
        bit_pos_next   = bit_pos_reg;
        pend_mask_next = pend_mask_reg;
        pend_bits_next = pend_bits_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_addr_next    = m_addr_reg;
        m_mask_next    = m_mask_reg;
        m_data_next    = m_data_reg;
        m_end_next     = m_end_reg;
        if (cmd.load) begin
            // Place the transfer start
            row_next       = start_row;
            line_base_next = ADDR_W'(ADDR_W'(start_row) * RowStep);
            column_next    = start_col;
            bit_pos_next   = start_col[2:0];
            pend_mask_next = MASK_FULL >> start_col[2:0];
            pend_bits_next = '0;
        end else if (cmd.step && !dropped) begin
            if (edge_hit) begin
                // Flush the partial byte and move to the next row
                m_valid_next   = 1'b1;
                m_addr_next    = cur_addr;
                m_mask_next    = pend_mask_reg & tail_mask;
                m_data_next    = bits_new & pend_mask_reg & tail_mask;
                m_end_next     = s_last_pixel;
                row_next       = row_sat ? row_reg : row_reg + ROW_W'(1);
                line_base_next = row_sat ? line_base_reg : line_base_reg + RowStep;
                column_next    = left_col;
                bit_pos_next   = left_col[2:0];
                pend_mask_next = MASK_FULL >> left_col[2:0];
                pend_bits_next = '0;
            end else if (bit_pos_reg == BIT_LAST) begin
                // Byte full: write it out
                m_valid_next   = 1'b1;
                m_addr_next    = cur_addr;
                m_mask_next    = pend_mask_reg;
                m_data_next    = bits_new & pend_mask_reg;
                m_end_next     = 1'b0;
                column_next    = column_reg + COL_W'(1);
                bit_pos_next   = '0;
                pend_mask_next = MASK_FULL;
                pend_bits_next = '0;
            end else begin
                // Advance within the byte
                column_next    = column_reg + COL_W'(1);
                bit_pos_next   = bit_pos_reg + 3'd1;
                pend_bits_next = bits_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg    <= '0;
            row_reg       <= '0;
            line_base_reg <= '0;
            bit_pos_reg   <= '0;
            pend_mask_reg <= MASK_FULL;
            pend_bits_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            column_reg    <= column_next;
            row_reg       <= row_next;
            line_base_reg <= line_base_next;
            bit_pos_reg   <= bit_pos_next;
            pend_mask_reg <= pend_mask_next;
            pend_bits_reg <= pend_bits_next;
            m_valid_reg   <= m_valid_next;
        end
        m_addr_reg <= m_addr_next;
        m_mask_reg <= m_mask_next;
        m_data_reg <= m_data_next;
        m_end_reg  <= m_end_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_byte_address = m_addr_reg;
    assign m_bit_mask     = m_mask_reg;
    assign m_write_data   = m_data_reg;
    assign m_transfer_end = m_end_reg;

endmodule
`default_nettype wire

>>> hdl/pbp_ctrl.sv
// Transfer controller: idle, start division, then stream pixels.
// Depends on pbp_pkg for the state type and command/status bundles.
`timescale 1ns / 1ps
`default_nettype none
module pbp_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    input  wire                   s_last_pixel,
    input  wire                   cfg_wr,
    input  pbp_pkg::ctrl_stat_t   stat,
    output pbp_pkg::ctrl_cmd_t    cmd,
    output logic                  s_ready
);
    import pbp_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    assign accept = s_valid && s_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && !cfg_wr) state_next = ST_DIV;
            end
            ST_DIV: begin
                // A register write restarts the division with fresh operands
                if (cfg_wr)             state_next = ST_IDLE;
                else if (stat.div_done) state_next = ST_RUN;
            end
            ST_RUN: begin
                if (accept && s_last_pixel) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.div_start = s_valid && !cfg_wr;
            end
            ST_DIV: begin
                cmd.load = stat.div_done && !cfg_wr;
            end
            ST_RUN: begin
                s_ready  = stat.out_free;
                cmd.step = s_valid && stat.out_free;
            end
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> tb/planar_write_checker.sv
// Checker for the pixel to planar byte packer: predicts frame writes and compares them.
// Watches the APB-style port, the s_ pixel channel and the m_ write channel.
// Depends on pbp_pkg for the register indexes, the configuration record and bit patterns.
`timescale 1ns / 1ps
module planar_write_checker #(
    parameter int ROW_BYTES = pbp_pkg::ROW_BYTES_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [4:0]   paddr,
    input  wire [31:0]  pwdata,
    input  wire         pready,
    input  wire         s_valid,
    input  wire         s_ready,
    input  wire [7:0]   s_pixel,
    input  wire         s_last_pixel,
    input  wire         m_valid,
    input  wire         m_ready,
    input  wire [15:0]  m_byte_address,
    input  wire [7:0]   m_bit_mask,
    input  wire [7:0]   m_write_data,
    input  wire         m_transfer_end,
    output int          fail_count,
    output int          writes_outstanding
);
    import pbp_pkg::*;

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  mask;
        logic [7:0]  data;
        logic        closes;
    } frame_write_t;

    frame_write_t writes_due[$];

    // Shadow copy of the registers
    cfg_t rect_cfg;

    // Packing state: 11-bit column, saturating row
    logic [10:0] col_q;
    logic [8:0]  row_q;
    logic [15:0] line_base_q;
    logic [2:0]  bit_pos_q;
    logic [7:0]  mask_q;
    logic [7:0]  bits_q;
    logic        busy_q;

    initial begin
        fail_count = 0;
        writes_outstanding = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic goto_row(input int unsigned r);
        row_q = (r > ROW_MAX) ? ROW_MAX : r[8:0];
        line_base_q = 16'(row_q * ROW_BYTES);
    endtask

    task automatic goto_column(input int unsigned c);
        col_q = 11'(c);
        bit_pos_q = col_q[2:0];
        mask_q = MASK_FULL >> bit_pos_q;
        bits_q = '0;
    endtask

    task automatic queue_write(input logic [7:0] m, input logic closes);
        frame_write_t w;
        w.addr = 16'(line_base_q + (col_q >> 3));
        w.mask = m;
        w.data = bits_q & m;
        w.closes = closes;
        writes_due.push_back(w);
    endtask

    // Advance the packer by one pixel and queue the write it causes, if any
    task automatic pack_pixel(input logic [7:0] pix, input logic last);
        int unsigned wid;
        int unsigned right;
        int          bottom;
        logic [7:0]  m;
        wid = (rect_cfg.rect_width == 0) ? 1 : rect_cfg.rect_width;
        bottom = int'(rect_cfg.rect_top) + int'(rect_cfg.rect_height) - 1;
        right = rect_cfg.rect_left + wid - 1;
        // start of a transfer: split the offset into row and column
        if (!busy_q) begin
            goto_row(rect_cfg.start_offset / wid + rect_cfg.rect_top);
            goto_column(rect_cfg.start_offset % wid + rect_cfg.rect_left);
            busy_q = 1'b1;
        end
        // drop rows below the bottom edge
        if (int'(row_q) > bottom) begin
            if (last)
                busy_q = 1'b0;
            return;
        end
        if (pix[FG_BIT])
            bits_q |= BIT_MSB >> bit_pos_q;
        if (last || col_q >= right) begin
            m = mask_q;
            if (bit_pos_q != BIT_LAST)
                m &= MASK_FULL << (BIT_LAST - bit_pos_q);
            queue_write(m, last);
            goto_row(row_q + 1);
            goto_column(rect_cfg.rect_left);
            if (last)
                busy_q = 1'b0;
        end else if (bit_pos_q == BIT_LAST) begin
            queue_write(mask_q, 1'b0);
            col_q = col_q + 1'b1;
            bit_pos_q = '0;
            mask_q = MASK_FULL;
            bits_q = '0;
        end else begin
            col_q = col_q + 1'b1;
            bit_pos_q = bit_pos_q + 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        frame_write_t w;
        if (!aresetn) begin
            rect_cfg.rect_left = '0;
            rect_cfg.rect_top = '0;
            rect_cfg.rect_width = 10'd640;
            rect_cfg.rect_height = 9'd480;
            rect_cfg.start_offset = '0;
            col_q = '0;
            row_q = '0;
            line_base_q = '0;
            bit_pos_q = '0;
            mask_q = MASK_FULL;
            bits_q = '0;
            busy_q = 1'b0;
            writes_due.delete();
        end else begin
            // compare each taken write with the oldest prediction
            if (m_valid && m_ready) begin
                if (writes_due.size() == 0) begin
                    report_mismatch($sformatf("write addr %h mask %h data %h with none due",
                                              m_byte_address, m_bit_mask, m_write_data));
                end else begin
                    w = writes_due.pop_front();
                    if (m_byte_address !== w.addr)
                        report_mismatch($sformatf("byte_address %h, want %h",
                                                  m_byte_address, w.addr));
                    if (m_bit_mask !== w.mask)
                        report_mismatch($sformatf("bit_mask %h, want %h at addr %h",
                                                  m_bit_mask, w.mask, w.addr));
                    if (m_write_data !== w.data)
                        report_mismatch($sformatf("write_data %h, want %h at addr %h",
                                                  m_write_data, w.data, w.addr));
                    if (m_transfer_end !== w.closes)
                        report_mismatch($sformatf("transfer_end %b, want %b at addr %h",
                                                  m_transfer_end, w.closes, w.addr));
                end
            end
            // predict from each taken pixel
            if (s_valid && s_ready)
                pack_pixel(s_pixel, s_last_pixel);
            // track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_LEFT:   rect_cfg.rect_left = pwdata[WID_W-1:0];
                    REG_TOP:    rect_cfg.rect_top = pwdata[ROW_W-1:0];
                    REG_WIDTH:  rect_cfg.rect_width = pwdata[WID_W-1:0];
                    REG_HEIGHT: rect_cfg.rect_height = pwdata[ROW_W-1:0];
                    REG_OFFSET: rect_cfg.start_offset = pwdata[OFFS_W-1:0];
                    default: ;
                endcase
            end
        end
        writes_outstanding = writes_due.size();
    end

endmodule

>>> tb/pixel_to_planar_byte_packer_core_tb.sv
// Testbench top for the pixel to planar byte packer: clock, reset, stimulus and verdict.
// Drives the register port, the pixel stream and the write-side stalls.
// Depends on pbp_pkg, pixel_to_planar_byte_packer_core and planar_write_checker.
`timescale 1ns / 1ps
module pixel_to_planar_byte_packer_core_tb;
    import pbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_PIXELS = 600;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_pixel = '0;
    logic        s_last_pixel = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_byte_address;
    logic [7:0]  m_bit_mask;
    logic [7:0]  m_write_data;
    logic        m_transfer_end;

    int   fail_count;
    int   writes_outstanding;
    int   burst_left = 0;
    int   idle_cycles = 0;
    logic hold_go = 1'b0;

    pixel_to_planar_byte_packer_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel        (s_pixel),
        .s_last_pixel   (s_last_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_address (m_byte_address),
        .m_bit_mask     (m_bit_mask),
        .m_write_data   (m_write_data),
        .m_transfer_end (m_transfer_end)
    );

    planar_write_checker write_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_pixel            (s_pixel),
        .s_last_pixel       (s_last_pixel),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_byte_address     (m_byte_address),
        .m_bit_mask         (m_bit_mask),
        .m_write_data       (m_write_data),
        .m_transfer_end     (m_transfer_end),
        .fail_count         (fail_count),
        .writes_outstanding (writes_outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: end the run after too long without any request moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Write side: stretches of stall modes, plus one long hold-off on request
    initial begin : write_side
        int         stretch;
        int         mode;
        logic       hold_seen;
        logic [7:0] stall_pat;
        hold_seen = 1'b0;
        stall_pat = 8'b1011_0110;
        forever begin
            mode = $urandom_range(0, 3);
            stretch = $urandom_range(10, 120);
            repeat (stretch) begin
                @(posedge aclk);
                if (hold_go != hold_seen) begin
                    // hold off long enough for the block to back up into s_ready
                    hold_seen = hold_go;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        stall_pat = {stall_pat[6:0], stall_pat[7]};
                        m_ready <= stall_pat[0];
                    end
                endcase
            end
        end
    end

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_rect(input logic [9:0] left, input logic [8:0] top,
                                input logic [9:0] wid, input logic [8:0] hgt,
                                input logic [18:0] offs);
        apb_write(REG_LEFT, 32'(left));
        apb_write(REG_TOP, 32'(top));
        apb_write(REG_WIDTH, 32'(wid));
        apb_write(REG_HEIGHT, 32'(hgt));
        apb_write(REG_OFFSET, 32'(offs));
    endtask

    // Offer one pixel in bursts with random gaps; return once it is taken
    task automatic push_pixel(input logic [7:0] pix, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_pixel <= pix;
        s_last_pixel <= last;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    // Drop valid, wait for every write to arrive, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (writes_outstanding != 0) @(negedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // Random rectangle, mostly narrow and short so edges and row ends come often
    task automatic rand_rect();
        logic [9:0]  left;
        logic [8:0]  top;
        logic [9:0]  wid;
        logic [8:0]  hgt;
        logic [18:0] offs;
        int unsigned eff;
        case ($urandom_range(0, 7))
            0: left = 10'd0;
            1: left = 10'd1023;
            2: left = 10'($urandom_range(640, 1023));
            default: left = 10'($urandom_range(0, 639));
        endcase
        case ($urandom_range(0, 7))
            0: top = 9'd0;
            1: top = 9'd511;
            default: top = 9'($urandom_range(0, 479));
        endcase
        case ($urandom_range(0, 19))
            0, 1: wid = 10'd0;
            2: wid = 10'd1023;
            3, 4, 5: wid = 10'($urandom_range(25, 640));
            6: wid = 10'($urandom_range(641, 1022));
            default: wid = 10'($urandom_range(1, 24));
        endcase
        case ($urandom_range(0, 9))
            0: hgt = 9'd0;
            1: hgt = 9'd511;
            2: hgt = 9'($urandom_range(21, 480));
            default: hgt = 9'($urandom_range(1, 20));
        endcase
        eff = (wid == 0) ? 1 : wid;
        case ($urandom_range(0, 15))
            0: offs = 19'h7ffff;
            1, 2: offs = 19'($urandom_range(0, 19'h7ffff));
            default: offs = 19'($urandom_range(0, hgt + 2) * eff + $urandom_range(0, eff - 1));
        endcase
        program_rect(left, top, wid, hgt, offs);
    endtask

    initial begin : stimulus
        int sent;
        int phase;
        int xfers;
        int len;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset geometry: all-ones, all-zeros and single foreground bits
        push_pixel(8'hff, 1'b0);
        push_pixel(8'h04, 1'b0);
        push_pixel(8'h00, 1'b0);
        push_pixel(8'hfb, 1'b0);
        push_pixel(8'h80, 1'b0);
        push_pixel(8'h7f, 1'b0);
        push_pixel(8'h01, 1'b0);
        push_pixel(8'h02, 1'b0);
        push_pixel(8'h04, 1'b1);
        // one-pixel transfer
        push_pixel(8'h04, 1'b1);
        settle();

        // Zero width acts as one: every pixel hits the right edge, then rows run out
        program_rect(10'd1023, 9'd5, 10'd0, 9'd2, 19'd1);
        push_pixel(8'hff, 1'b0);
        push_pixel(8'h04, 1'b0);
        push_pixel(8'h00, 1'b1);
        settle();

        // Zero height: everything dropped, the last pixel still closes the transfer
        program_rect(10'd0, 9'd479, 10'd640, 9'd0, 19'd0);
        push_pixel(8'h04, 1'b0);
        push_pixel(8'h04, 1'b1);
        settle();

        // Columns running past 1023
        program_rect(10'd1020, 9'd0, 10'd640, 9'd480, 19'd0);
        push_pixel(8'h04, 1'b0);
        push_pixel(8'hfb, 1'b0);
        push_pixel(8'h04, 1'b0);
        push_pixel(8'h04, 1'b0);
        push_pixel(8'hff, 1'b0);
        push_pixel(8'h04, 1'b1);
        settle();

        // Row counter saturated at its top, largest offset
        program_rect(10'd639, 9'd511, 10'd1, 9'd511, 19'h7ffff);
        push_pixel(8'h04, 1'b0);
        push_pixel(8'h00, 1'b0);
        push_pixel(8'hff, 1'b1);
        settle();

        // Random phases: new geometry, then a few whole transfers
        sent = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            if (phase == 2) begin
                program_rect(10'($urandom_range(0, 639)), 9'($urandom_range(0, 400)),
                             10'd8, 9'd64, 19'd0);
                hold_go <= ~hold_go;
                xfers = 1;
            end else begin
                rand_rect();
                xfers = $urandom_range(1, 3);
            end
            repeat (xfers) begin
                if (phase == 2)
                    len = 64;
                else
                    len = $urandom_range(0, 9) < 7 ? $urandom_range(1, 24)
                                                   : $urandom_range(25, 80);
                for (int i = 0; i < len; i++) begin
                    push_pixel(8'($urandom_range(0, 255)), i == len - 1);
                    sent++;
                end
            end
            settle();
            phase++;
        end

        if (fail_count == 0 && writes_outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
